// ===== rtl/ccfa_pkg.sv =====
// Shared types and constants for the cut-cell face area fraction block.
// Used by ccfa_ctrl, ccfa_datapath, the top level and ccfa_checker.
package ccfa_pkg;

  localparam int FracBits = 16;
  localparam int CellBits = 24;

  localparam int CoordW  = 32;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 3;
  localparam int FaceW   = 3;
  localparam int CellW   = 24;
  localparam int AreaW   = 32;
  localparam int FracW   = FracBits + 1;
  localparam int MulW    = 33;
  localparam int ProdW   = 64;
  localparam int AccW    = 64;
  localparam int LoShift = 25;
  localparam int LoW     = ProdW - LoShift;

  localparam int SFieldW = 3 * CoordW + FaceW + CellW;
  localparam int SDataW  = ((SFieldW + 7) / 8) * 8;
  localparam int SPadW   = SDataW - SFieldW;
  localparam int MFieldW = AreaW + FracW + CellW;
  localparam int MDataW  = ((MFieldW + 7) / 8) * 8;
  localparam int MPadW   = MDataW - MFieldW;

  localparam logic [CfgIdxW-1:0] CfgInvDyDz  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInvDxDz  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgInvDxDy  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAreaDyDz = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAreaDxDz = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAreaDxDy = 3'd5;

  localparam logic [CfgW-1:0] InvReset  = 32'h0100_0000;
  localparam logic [CfgW-1:0] AreaReset = 32'h0001_0000;

  // last face code of each face pair
  localparam logic [FaceW-1:0] FaceXzLast = 3'd1;
  localparam logic [FaceW-1:0] FaceYzLast = 3'd3;
  localparam logic [FaceW-1:0] FaceXyLast = 3'd5;

  localparam logic [1:0] TermYz = 2'd0;
  localparam logic [1:0] TermXz = 2'd1;
  localparam logic [1:0] TermXy = 2'd2;

  localparam logic signed [AccW-1:0] SatMax   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [AccW-1:0] CoeffMin = 64'sd214748365;
  localparam logic signed [AccW-1:0] OneQ32   = 64'sh0000_0001_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LOAD,
    ST_MUL_SD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_TERM,
    ST_ACC,
    ST_EDGE_END,
    ST_CLAMP,
    ST_FACTOR,
    ST_MUL_AREA,
    ST_EMIT
  } ccfa_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_FIRST,
    OP_LOAD,
    OP_MUL_OPS,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_TERM,
    OP_ACC,
    OP_ADVANCE,
    OP_CLOSE,
    OP_CLAMP,
    OP_FACTOR,
    OP_EMIT
  } ccfa_op_e;

  typedef struct packed {
    ccfa_op_e   op;
    logic [1:0] term;
    logic       close;
  } ccfa_cmd_t;

  typedef struct packed {
    logic in_poly;
    logic last;
    logic empty;
    logic out_free;
  } ccfa_stat_t;

endpackage

// ===== rtl/ccfa_ctrl.sv =====
// Sequencer for the cut-cell face area fraction block.
// Issues ccfa_pkg commands to ccfa_datapath and reads its status.
module ccfa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ccfa_pkg::ccfa_stat_t stat_i,
  output ccfa_pkg::ccfa_cmd_t  cmd_o
);

  ccfa_pkg::ccfa_state_e state_q, state_d;
  logic [1:0]            term_q, term_d;
  logic                  close_q, close_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccfa_pkg::ST_IDLE;
      term_q  <= ccfa_pkg::TermYz;
      close_q <= 1'b0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      close_q <= close_d;
    end
  end

  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    close_d = close_q;
    case (state_q)
      ccfa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ccfa_pkg::ST_START;
      end
      ccfa_pkg::ST_START: begin
        term_d = ccfa_pkg::TermYz;
        if (stat_i.empty) begin
          state_d = ccfa_pkg::ST_CLAMP;
        end else if (!stat_i.in_poly) begin
          if (stat_i.last) begin
            close_d = 1'b1;
            state_d = ccfa_pkg::ST_LOAD;
          end else begin
            state_d = ccfa_pkg::ST_IDLE;
          end
        end else begin
          close_d = 1'b0;
          state_d = ccfa_pkg::ST_LOAD;
        end
      end
      ccfa_pkg::ST_LOAD:   state_d = ccfa_pkg::ST_MUL_SD;
      ccfa_pkg::ST_MUL_SD: state_d = ccfa_pkg::ST_MUL_LO;
      ccfa_pkg::ST_MUL_LO: state_d = ccfa_pkg::ST_MUL_HI;
      ccfa_pkg::ST_MUL_HI: state_d = ccfa_pkg::ST_TERM;
      ccfa_pkg::ST_TERM:   state_d = ccfa_pkg::ST_ACC;
      ccfa_pkg::ST_ACC: begin
        if (term_q == ccfa_pkg::TermXy) begin
          state_d = ccfa_pkg::ST_EDGE_END;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = ccfa_pkg::ST_LOAD;
        end
      end
      ccfa_pkg::ST_EDGE_END: begin
        term_d = ccfa_pkg::TermYz;
        if (close_q) begin
          state_d = ccfa_pkg::ST_CLAMP;
        end else if (stat_i.last) begin
          close_d = 1'b1;
          state_d = ccfa_pkg::ST_LOAD;
        end else begin
          state_d = ccfa_pkg::ST_IDLE;
        end
      end
      ccfa_pkg::ST_CLAMP:    state_d = ccfa_pkg::ST_FACTOR;
      ccfa_pkg::ST_FACTOR:   state_d = ccfa_pkg::ST_MUL_AREA;
      ccfa_pkg::ST_MUL_AREA: state_d = ccfa_pkg::ST_EMIT;
      ccfa_pkg::ST_EMIT: begin
        if (stat_i.out_free) state_d = ccfa_pkg::ST_IDLE;
      end
      default: state_d = ccfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.op    = ccfa_pkg::OP_NONE;
    cmd_o.term  = term_q;
    cmd_o.close = close_q;
    case (state_q)
      ccfa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = ccfa_pkg::OP_LATCH;
      end
      ccfa_pkg::ST_START: begin
        if (stat_i.empty) begin
          cmd_o.op = ccfa_pkg::OP_CLEAR;
        end else if (!stat_i.in_poly) begin
          cmd_o.op = ccfa_pkg::OP_FIRST;
        end
      end
      ccfa_pkg::ST_LOAD:     cmd_o.op = ccfa_pkg::OP_LOAD;
      ccfa_pkg::ST_MUL_SD:   cmd_o.op = ccfa_pkg::OP_MUL_OPS;
      ccfa_pkg::ST_MUL_LO:   cmd_o.op = ccfa_pkg::OP_MUL_LO;
      ccfa_pkg::ST_MUL_HI:   cmd_o.op = ccfa_pkg::OP_MUL_HI;
      ccfa_pkg::ST_TERM:     cmd_o.op = ccfa_pkg::OP_TERM;
      ccfa_pkg::ST_ACC:      cmd_o.op = ccfa_pkg::OP_ACC;
      ccfa_pkg::ST_EDGE_END: begin
        cmd_o.op = close_q ? ccfa_pkg::OP_CLOSE : ccfa_pkg::OP_ADVANCE;
      end
      ccfa_pkg::ST_CLAMP:    cmd_o.op = ccfa_pkg::OP_CLAMP;
      ccfa_pkg::ST_FACTOR:   cmd_o.op = ccfa_pkg::OP_FACTOR;
      ccfa_pkg::ST_MUL_AREA: cmd_o.op = ccfa_pkg::OP_MUL_OPS;
      ccfa_pkg::ST_EMIT: begin
        if (stat_i.out_free) cmd_o.op = ccfa_pkg::OP_EMIT;
      end
      default: cmd_o.op = ccfa_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== rtl/ccfa_datapath.sv =====
// Datapath: configuration registers, vertex state, shared 33x33 multiplier,
// saturating accumulator and output register. Uses ccfa_pkg.
module ccfa_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ccfa_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ccfa_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic [ccfa_pkg::SDataW-1:0]        in_data_i,
  input  logic                               in_last_i,
  input  logic                               in_empty_i,
  input  ccfa_pkg::ccfa_cmd_t                cmd_i,
  output ccfa_pkg::ccfa_stat_t               stat_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ccfa_pkg::MDataW-1:0]        out_data_o,
  output logic [ccfa_pkg::FaceW-1:0]         out_face_o
);

  localparam int CW = ccfa_pkg::CoordW;
  localparam int SW = ccfa_pkg::CoordW + 1;
  localparam int AW = ccfa_pkg::AccW;
  localparam int FB = ccfa_pkg::FracBits;
  localparam logic signed [AW:0] AccMax = {1'b0, ccfa_pkg::SatMax};
  localparam logic signed [AW:0] AccMin = -AccMax;
  localparam logic [ccfa_pkg::MulW-1:0] OneC = 33'h1_0000_0000;
  localparam logic [ccfa_pkg::FracW-1:0] FracOne = {1'b1, {FB{1'b0}}};
  localparam logic [ccfa_pkg::ProdW-1:0] RoundHalf = 64'h0000_0000_8000_0000;

  logic [ccfa_pkg::CfgW-1:0] inv_dy_dz_q, inv_dx_dz_q, inv_dx_dy_q;
  logic [ccfa_pkg::CfgW-1:0] area_dy_dz_q, area_dx_dz_q, area_dx_dy_q;

  logic [CW-1:0] cur_x_q, cur_y_q, cur_z_q;
  logic [CW-1:0] first_x_q, first_y_q, first_z_q;
  logic [CW-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic [ccfa_pkg::FaceW-1:0] face_q;
  logic [ccfa_pkg::CellW-1:0] cell_q;
  logic last_q, empty_q;

  logic signed [AW-1:0] coeff_q, coeff_d;
  logic in_poly_q;

  logic [ccfa_pkg::MulW-1:0]  op_a_q, op_b_q;
  logic                       neg_q;
  logic [ccfa_pkg::ProdW-1:0] prod_q;
  logic [CW-1:0]              phi_q;
  logic [ccfa_pkg::LoW-1:0]   lo_q;
  logic signed [AW-1:0]       term_q, term_d;
  logic [ccfa_pkg::MulW-1:0]  c_q, c_d;
  logic [ccfa_pkg::FracW-1:0] frac_q, frac_d;

  logic                         out_valid_q;
  logic [ccfa_pkg::AreaW-1:0]   out_area_q;
  logic [ccfa_pkg::FracW-1:0]   out_frac_q;
  logic [ccfa_pkg::FaceW-1:0]   out_face_q;
  logic [ccfa_pkg::CellW-1:0]   out_cell_q;

  logic [CW-1:0] q_x, q_y, q_z;
  logic [SW-1:0] sum_x, sum_y, dif_y, dif_z, s_val, d_val, s_mag, d_mag;
  logic          neg;
  logic [ccfa_pkg::CfgW-1:0] inv_sel;
  logic [ccfa_pkg::MulW-1:0] mul_a, mul_b;
  logic [2*ccfa_pkg::MulW-1:0] mul_full;
  logic [AW-1:0] r_sum, r_val;
  logic signed [AW:0] acc_wide;
  logic [ccfa_pkg::MulW-1:0] factor;
  logic [ccfa_pkg::CfgW-1:0] area_sel;
  logic [ccfa_pkg::MulW:0]   cf_sum;
  logic [ccfa_pkg::FracW-1:0] cf;
  logic [ccfa_pkg::ProdW-1:0] rounded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_dy_dz_q  <= ccfa_pkg::InvReset;
      inv_dx_dz_q  <= ccfa_pkg::InvReset;
      inv_dx_dy_q  <= ccfa_pkg::InvReset;
      area_dy_dz_q <= ccfa_pkg::AreaReset;
      area_dx_dz_q <= ccfa_pkg::AreaReset;
      area_dx_dy_q <= ccfa_pkg::AreaReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ccfa_pkg::CfgInvDyDz:  inv_dy_dz_q  <= cfg_wdata_i;
        ccfa_pkg::CfgInvDxDz:  inv_dx_dz_q  <= cfg_wdata_i;
        ccfa_pkg::CfgInvDxDy:  inv_dx_dy_q  <= cfg_wdata_i;
        ccfa_pkg::CfgAreaDyDz: area_dy_dz_q <= cfg_wdata_i;
        ccfa_pkg::CfgAreaDxDz: area_dx_dz_q <= cfg_wdata_i;
        ccfa_pkg::CfgAreaDxDy: area_dx_dy_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // edge operands: P is prev, Q is the new vertex or, when closing, the first
  always_comb begin
    q_x   = cmd_i.close ? first_x_q : cur_x_q;
    q_y   = cmd_i.close ? first_y_q : cur_y_q;
    q_z   = cmd_i.close ? first_z_q : cur_z_q;
    sum_x = {prev_x_q[CW-1], prev_x_q} + {q_x[CW-1], q_x};
    sum_y = {prev_y_q[CW-1], prev_y_q} + {q_y[CW-1], q_y};
    dif_y = {q_y[CW-1], q_y} - {prev_y_q[CW-1], prev_y_q};
    dif_z = {q_z[CW-1], q_z} - {prev_z_q[CW-1], prev_z_q};
    case (cmd_i.term)
      ccfa_pkg::TermYz: begin
        s_val   = sum_y;
        d_val   = dif_z;
        inv_sel = inv_dy_dz_q;
      end
      ccfa_pkg::TermXz: begin
        s_val   = sum_x;
        d_val   = dif_z;
        inv_sel = inv_dx_dz_q;
      end
      default: begin
        s_val   = sum_x;
        d_val   = dif_y;
        inv_sel = inv_dx_dy_q;
      end
    endcase
    s_mag = s_val[SW-1] ? (~s_val + SW'(1)) : s_val;
    d_mag = d_val[SW-1] ? (~d_val + SW'(1)) : d_val;
    neg   = s_val[SW-1] ^ d_val[SW-1];
  end

  always_comb begin
    case (cmd_i.op)
      ccfa_pkg::OP_MUL_LO: begin
        mul_a = {1'b0, prod_q[CW-1:0]};
        mul_b = {1'b0, inv_sel};
      end
      ccfa_pkg::OP_MUL_HI: begin
        mul_a = {1'b0, phi_q};
        mul_b = {1'b0, inv_sel};
      end
      default: begin
        mul_a = op_a_q;
        mul_b = op_b_q;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // term = sat((hi << 7) + (lo >> 25)), hi held in prod_q, sign applied last
  always_comb begin
    r_sum  = {prod_q[AW-8:0], 7'd0} + {{ccfa_pkg::LoShift{1'b0}}, lo_q};
    r_val  = ((|prod_q[AW-1:AW-8]) || r_sum[AW-1]) ? ccfa_pkg::SatMax : r_sum;
    term_d = neg_q ? $signed(AW'(0) - r_val) : $signed(r_val);
  end

  always_comb begin
    acc_wide = $signed({coeff_q[AW-1], coeff_q}) + $signed({term_q[AW-1], term_q});
    if (acc_wide > AccMax) begin
      coeff_d = ccfa_pkg::SatMax;
    end else if (acc_wide < AccMin) begin
      coeff_d = -ccfa_pkg::SatMax;
    end else begin
      coeff_d = acc_wide[AW-1:0];
    end
  end

  always_comb begin
    if (coeff_q <= ccfa_pkg::CoeffMin) begin
      c_d = '0;
    end else if (coeff_q > ccfa_pkg::OneQ32) begin
      c_d = OneC;
    end else begin
      c_d = coeff_q[ccfa_pkg::MulW-1:0];
    end
  end

  always_comb begin
    cf_sum = {1'b0, c_q} + ((ccfa_pkg::MulW + 1)'(1) << (31 - FB));
    cf     = cf_sum[32:32-FB];
    if (face_q <= ccfa_pkg::FaceYzLast) begin
      factor   = OneC - c_q;
      area_sel = (face_q <= ccfa_pkg::FaceXzLast) ? area_dx_dz_q : area_dy_dz_q;
      frac_d   = cf;
    end else if (face_q <= ccfa_pkg::FaceXyLast) begin
      factor   = c_q;
      area_sel = area_dx_dy_q;
      frac_d   = FracOne - cf;
    end else begin
      factor   = '0;
      area_sel = '0;
      frac_d   = '0;
    end
  end

  assign rounded = prod_q + RoundHalf;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ccfa_pkg::OP_LATCH: begin
        cur_x_q <= in_data_i[CW-1:0];
        cur_y_q <= in_data_i[2*CW-1:CW];
        cur_z_q <= in_data_i[3*CW-1:2*CW];
        face_q  <= in_data_i[3*CW +: ccfa_pkg::FaceW];
        cell_q  <= in_data_i[3*CW+ccfa_pkg::FaceW +: ccfa_pkg::CellW];
        last_q  <= in_last_i;
        empty_q <= in_empty_i;
      end
      ccfa_pkg::OP_FIRST: begin
        first_x_q <= cur_x_q;
        first_y_q <= cur_y_q;
        first_z_q <= cur_z_q;
        prev_x_q  <= cur_x_q;
        prev_y_q  <= cur_y_q;
        prev_z_q  <= cur_z_q;
      end
      ccfa_pkg::OP_ADVANCE: begin
        prev_x_q <= cur_x_q;
        prev_y_q <= cur_y_q;
        prev_z_q <= cur_z_q;
      end
      ccfa_pkg::OP_LOAD: begin
        op_a_q <= s_mag;
        op_b_q <= d_mag;
        neg_q  <= neg;
      end
      ccfa_pkg::OP_MUL_OPS: prod_q <= mul_full[ccfa_pkg::ProdW-1:0];
      ccfa_pkg::OP_MUL_LO: begin
        prod_q <= mul_full[ccfa_pkg::ProdW-1:0];
        phi_q  <= prod_q[ccfa_pkg::ProdW-1:CW];
      end
      ccfa_pkg::OP_MUL_HI: begin
        prod_q <= mul_full[ccfa_pkg::ProdW-1:0];
        lo_q   <= prod_q[ccfa_pkg::ProdW-1:ccfa_pkg::LoShift];
      end
      ccfa_pkg::OP_TERM:  term_q <= term_d;
      ccfa_pkg::OP_CLAMP: c_q <= c_d;
      ccfa_pkg::OP_FACTOR: begin
        op_a_q <= factor;
        op_b_q <= {1'b0, area_sel};
        frac_q <= frac_d;
      end
      ccfa_pkg::OP_EMIT: begin
        out_area_q <= rounded[ccfa_pkg::ProdW-1:CW];
        out_frac_q <= frac_q;
        out_face_q <= face_q;
        out_cell_q <= ccfa_pkg::CellW'(cell_q[ccfa_pkg::CellBits-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q   <= '0;
      in_poly_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        ccfa_pkg::OP_CLEAR: begin
          coeff_q   <= '0;
          in_poly_q <= 1'b0;
        end
        ccfa_pkg::OP_FIRST: begin
          coeff_q   <= '0;
          in_poly_q <= 1'b1;
        end
        ccfa_pkg::OP_ACC:   coeff_q <= coeff_d;
        ccfa_pkg::OP_CLOSE: in_poly_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == ccfa_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.in_poly  = in_poly_q;
  assign stat_o.last     = last_q;
  assign stat_o.empty    = empty_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{ccfa_pkg::MPadW{1'b0}}, out_cell_q, out_frac_q, out_area_q};
  assign out_face_o  = out_face_q;

endmodule

// ===== rtl/cut_cell_face_area_fraction.sv =====
// Cut-cell face area fraction: shoelace area of a cut polygon, one vertex per request.
// Opening vertex is only stored; an inner vertex adds one edge on the shared multiplier.
// Closing vertex adds its edge and the closing edge (only the latter if also first).
// Empty polygon: result from a cleared sum; a held result only holds up the next emit.
// Async active-low reset: config to 1.0, no polygon open, output empty. Uses ccfa_pkg.
module cut_cell_face_area_fraction (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // point_x, point_y, point_z, face, cell_index, zero pad
  input  logic [ccfa_pkg::SDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  // no_points
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // blocked_area, fraction, cell_out, zero pad
  output logic [ccfa_pkg::MDataW-1:0]   m_axis_tdata,
  // face_out
  output logic [ccfa_pkg::FaceW-1:0]    m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [ccfa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ccfa_pkg::CfgW-1:0]     cfg_wdata_i
);

  ccfa_pkg::ccfa_cmd_t  cmd;
  ccfa_pkg::ccfa_stat_t stat;

  ccfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ccfa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_empty_i  (s_axis_tuser),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_face_o  (m_axis_tuser)
  );

endmodule

// ===== rtl/ccfa_checker.sv =====
// Port-level checks for cut_cell_face_area_fraction, attached by bind.
// Uses ccfa_pkg for field positions and face codes.
module ccfa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ccfa_pkg::MDataW-1:0]   m_axis_tdata,
  input logic [ccfa_pkg::FaceW-1:0]    m_axis_tuser
);

  localparam logic [ccfa_pkg::FracW-1:0] FracOne = {1'b1, {ccfa_pkg::FracBits{1'b0}}};

  hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result dropped or changed while stalled");

  busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while the previous one is in work");

  fraction_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ccfa_pkg::AreaW +: ccfa_pkg::FracW] <= FracOne)
    else $error("fraction above one");

  bad_face_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser > ccfa_pkg::FaceXyLast) |->
      m_axis_tdata[ccfa_pkg::AreaW+ccfa_pkg::FracW-1:0] == '0)
    else $error("nonzero area or fraction for an unused face code");

endmodule

bind cut_cell_face_area_fraction ccfa_checker u_ccfa_checker (.*);
